// File: design/ps2_host_link_engine_defines.svh
// ----------------------------------------------------------------------------
// PS/2 host link engine assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef PS2_HOST_LINK_ENGINE_DEFINES_SVH
`define PS2_HOST_LINK_ENGINE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PS2HL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PS2HL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, also while reset is high.
`define PS2HL_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ps2hl_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 host link engine package
// Item types, register defaults and protocol codes.
// ----------------------------------------------------------------------------
package ps2hl_pkg;

  localparam int BYTE_W  = 8;
  localparam int TIMER_W = 16;
  localparam int CNT_W   = 4;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] ACT_EDGE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_SEND = 2'd2;
  localparam logic [1:0] ACT_POP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST = 1'd1;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [TIMER_W-1:0] REQUEST_RESET = 16'd8000;

  localparam logic [CNT_W-1:0] SEND_PENDING = 4'd12;
  localparam logic [CNT_W-1:0] SEND_FIRST   = 4'd11;
  localparam logic [CNT_W-1:0] SEND_RELEASE = 4'd2;
  localparam logic [CNT_W-1:0] SEND_ACK     = 4'd1;
  localparam logic [CNT_W-1:0] RECV_BITS    = 4'd10;

  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INHIBIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRIVE   = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic              data_in;
    logic [BYTE_W-1:0] command_byte;
  } ps2hl_in_t;

  typedef struct packed {
    logic              clock_drive_low;
    logic              data_drive_enable;
    logic              data_level;
    logic              fifo_empty;
    logic [BYTE_W-1:0] fifo_head_byte;
    logic              tx_idle;
  } ps2hl_out_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] data;
  } ps2hl_fifo_req_t;

  typedef struct packed {
    logic              empty;
    logic [BYTE_W-1:0] head;
  } ps2hl_fifo_stat_t;

  typedef struct packed {
    logic clock_drive_low;
    logic data_drive_enable;
    logic data_level;
    logic tx_idle;
  } ps2hl_link_t;

endpackage

// File: design/ps2hl_fifo.sv
// ----------------------------------------------------------------------------
// PS/2 host link receive FIFO
// Ring buffer with one slot kept free; registered head byte.
// ----------------------------------------------------------------------------
module ps2hl_fifo import ps2hl_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  ps2hl_fifo_req_t  req,
  output ps2hl_fifo_stat_t stat
);

  localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [BYTE_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  write_ptr, write_ptr_next;
  logic [PTR_W-1:0]  read_ptr, read_ptr_next;
  logic [PTR_W-1:0]  wr_succ, rd_succ;
  logic [BYTE_W-1:0] head;
  logic              wr_en;

  assign wr_succ = (write_ptr == LAST) ? '0 : write_ptr + 1'b1;
  assign rd_succ = (read_ptr == LAST) ? '0 : read_ptr + 1'b1;

  always_comb begin
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    wr_en          = 1'b0;
    if (step && req.push && wr_succ != read_ptr) begin
      wr_en          = 1'b1;
      write_ptr_next = wr_succ;
    end
    if (step && req.pop && write_ptr != read_ptr) begin
      read_ptr_next = rd_succ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
    end else begin
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_ptr] <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (write_ptr_next == read_ptr_next) begin
        head <= '0;
      end else if (wr_en && write_ptr == read_ptr_next) begin
        head <= req.data;
      end else begin
        head <= mem[read_ptr_next];
      end
    end
  end

  assign stat.empty = (write_ptr == read_ptr);
  assign stat.head  = head;

endmodule

// File: design/ps2hl_ctrl.sv
// ----------------------------------------------------------------------------
// PS/2 host link control
// Send and receive sequencing, line modes and the one-shot timer.
// ----------------------------------------------------------------------------
module ps2hl_ctrl import ps2hl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  ps2hl_in_t          item,
  input  logic [TIMER_W-1:0] timeout_ticks,
  input  logic [TIMER_W-1:0] request_ticks,
  output ps2hl_link_t        link_next,
  output ps2hl_fifo_req_t    fifo_req
);

  logic [CNT_W-1:0]   send_count, send_count_next;
  logic [8:0]         send_shift, send_shift_next;
  logic [CNT_W-1:0]   recv_count, recv_count_next;
  logic [9:0]         recv_shift, recv_shift_next;
  logic [TIMER_W-1:0] timer_count, timer_count_next;
  logic               timer_running, timer_running_next;
  logic [MODE_W-1:0]  line_mode, line_mode_next;
  logic               data_bit_out, data_bit_out_next;

  always_comb begin
    send_count_next    = send_count;
    send_shift_next    = send_shift;
    recv_count_next    = recv_count;
    recv_shift_next    = recv_shift;
    timer_count_next   = timer_count;
    timer_running_next = timer_running;
    line_mode_next     = line_mode;
    data_bit_out_next  = data_bit_out;
    fifo_req.push      = 1'b0;
    fifo_req.pop       = 1'b0;
    case (item.action)
      ACT_EDGE: begin
        timer_count_next   = timeout_ticks;
        timer_running_next = 1'b1;
        if (send_count == SEND_PENDING && recv_count == '0) begin
          timer_count_next = request_ticks;
        end else if (send_count != '0 && send_count != SEND_PENDING) begin
          send_count_next = send_count - 1'b1;
          if (send_count == SEND_RELEASE) begin
            line_mode_next = MODE_IDLE;
          end else if (send_count == SEND_ACK) begin
            timer_running_next = 1'b0;
          end else begin
            data_bit_out_next = send_shift[0];
            send_shift_next   = {1'b0, send_shift[8:1]};
          end
        end else if (recv_count != '0) begin
          recv_shift_next = {item.data_in, recv_shift[9:1]};
          recv_count_next = recv_count - 1'b1;
          if (recv_count == 4'd1) begin
            timer_running_next = 1'b0;
            fifo_req.push      = 1'b1;
            if (send_count == SEND_PENDING) begin
              line_mode_next     = MODE_INHIBIT;
              timer_count_next   = request_ticks;
              timer_running_next = 1'b1;
            end
          end
        end else begin
          recv_count_next = RECV_BITS;
        end
      end
      ACT_TICK: begin
        if (timer_running) begin
          if (timer_count <= 16'd1) begin
            timer_count_next   = '0;
            timer_running_next = 1'b0;
            recv_count_next    = '0;
            if (send_count == SEND_PENDING) begin
              timer_count_next   = timeout_ticks;
              timer_running_next = 1'b1;
              line_mode_next     = MODE_DRIVE;
              data_bit_out_next  = 1'b0;
              send_count_next    = SEND_FIRST;
            end
          end else begin
            timer_count_next = timer_count - 1'b1;
          end
        end
      end
      ACT_SEND: begin
        send_shift_next = {~^item.command_byte, item.command_byte};
        send_count_next = SEND_PENDING;
        if (recv_count == '0) begin
          line_mode_next     = MODE_INHIBIT;
          timer_count_next   = request_ticks;
          timer_running_next = 1'b1;
        end
      end
      ACT_POP: begin
        fifo_req.pop = 1'b1;
      end
      default: begin
      end
    endcase
    fifo_req.data = recv_shift_next[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_count    <= '0;
      send_shift    <= '0;
      recv_count    <= '0;
      recv_shift    <= '0;
      timer_count   <= '0;
      timer_running <= 1'b0;
      line_mode     <= MODE_IDLE;
      data_bit_out  <= 1'b0;
    end else if (step) begin
      send_count    <= send_count_next;
      send_shift    <= send_shift_next;
      recv_count    <= recv_count_next;
      recv_shift    <= recv_shift_next;
      timer_count   <= timer_count_next;
      timer_running <= timer_running_next;
      line_mode     <= line_mode_next;
      data_bit_out  <= data_bit_out_next;
    end
  end

  assign link_next.clock_drive_low   = (line_mode_next == MODE_INHIBIT);
  assign link_next.data_drive_enable = (line_mode_next == MODE_DRIVE);
  assign link_next.data_level        = (line_mode_next == MODE_DRIVE) && data_bit_out_next;
  assign link_next.tx_idle           = (send_count_next == '0);

endmodule

// File: design/ps2_host_link_engine.sv
// An accepted item is held in the input register, and its result is offered from the
// result register. Throughput: one item per cycle while res_ready does not stall; the
// two registers form a two-stage pipe, with all state updated in the single logic pass.
// Reset: synchronous rst clears the link state, timer, FIFO pointers and both
// valids, and loads the register defaults; the receive store is not cleared.
// ----------------------------------------------------------------------------
// PS/2 host link engine
// Top level: input register, control, receive FIFO, result register, config.
// ----------------------------------------------------------------------------
module ps2_host_link_engine import ps2hl_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ev_valid,
  output logic                 ev_ready,
  input  ps2hl_in_t            ev_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ps2hl_out_t           res_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIMER_W-1:0]   cfg_data
);

  ps2hl_in_t          in_q;
  logic               in_valid;
  logic               advance;
  logic               step;
  logic [TIMER_W-1:0] timeout_ticks;
  logic [TIMER_W-1:0] request_ticks;
  ps2hl_link_t        link_next;
  ps2hl_link_t        link_q;
  ps2hl_fifo_req_t    fifo_req;
  ps2hl_fifo_stat_t   fifo_stat;

  assign advance   = !res_valid || res_ready;
  assign step      = in_valid && advance;
  assign ev_ready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (ev_valid && ev_ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && ev_ready) begin
      in_q <= ev_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      request_ticks <= REQUEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_ticks <= cfg_data;
        CFG_REQUEST: request_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ps2hl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (in_q),
    .timeout_ticks (timeout_ticks),
    .request_ticks (request_ticks),
    .link_next     (link_next),
    .fifo_req      (fifo_req)
  );

  ps2hl_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (fifo_req),
    .stat (fifo_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      link_q <= link_next;
    end
  end

  assign res_item.clock_drive_low   = link_q.clock_drive_low;
  assign res_item.data_drive_enable = link_q.data_drive_enable;
  assign res_item.data_level        = link_q.data_level;
  assign res_item.fifo_empty        = fifo_stat.empty;
  assign res_item.fifo_head_byte    = fifo_stat.head;
  assign res_item.tx_idle           = link_q.tx_idle;

endmodule

// File: design/ps2hl_checker.sv
// ----------------------------------------------------------------------------
// PS/2 host link engine port checker
// Watches the result channel and bound to the top level.
// ----------------------------------------------------------------------------
`include "ps2_host_link_engine_defines.svh"

module ps2hl_checker import ps2hl_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input ps2hl_out_t res_item
);

  `PS2HL_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item), "result item changed while stalled")
  `PS2HL_ASSERT_NOW(a_mode_excl, res_valid, !(res_item.clock_drive_low && res_item.data_drive_enable), "clock inhibit and data drive both set")
  `PS2HL_ASSERT_NOW(a_level_off, res_valid && !res_item.data_drive_enable, !res_item.data_level, "data level set while data not driven")
  `PS2HL_ASSERT_NOW(a_empty_head, res_valid && res_item.fifo_empty, res_item.fifo_head_byte == '0, "head byte nonzero on empty fifo")
  `PS2HL_ASSERT_NEXT_ALWAYS(a_rst_valid, rst, !res_valid, "result valid right after reset")

endmodule

bind ps2_host_link_engine ps2hl_checker u_ps2hl_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item)
);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// PS/2 host link engine testbench
// Drives clock edges, timer ticks, commands and FIFO pops through the event
// channel under random sender gaps and receiver stalls. A local model of the
// link predicts the line and FIFO state after every item, and each result is
// checked field by field in order. Runs directed frames first, then random
// frame, send, timeout and pop traffic over several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import ps2hl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 ev_valid = 1'b0;
  logic                 ev_ready;
  ps2hl_in_t            ev_item = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  ps2hl_out_t           res_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIMER_W-1:0]   cfg_data = '0;

  ps2_host_link_engine uut (
    .clk(clk), .rst(rst),
    .ev_valid(ev_valid), .ev_ready(ev_ready), .ev_item(ev_item),
    .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // link model state
  logic [TIMER_W-1:0] m_timeout;
  logic [TIMER_W-1:0] m_request;
  logic [CNT_W-1:0]   m_send_cnt;
  logic [8:0]         m_send_sr;
  logic [CNT_W-1:0]   m_recv_cnt;
  logic [9:0]         m_recv_sr;
  logic [BYTE_W-1:0]  m_rx_mem [4];
  logic [1:0]         m_wr_ptr;
  logic [1:0]         m_rd_ptr;
  logic [TIMER_W-1:0] m_timer;
  logic               m_timer_on;
  logic [MODE_W-1:0]  m_mode;
  logic               m_data_bit;

  ps2hl_out_t line_state_q[$];
  int errors = 0;
  int sent_items = 0;
  int burst_left = 0;
  int cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  function automatic void reset_link_model();
    m_timeout  = TIMEOUT_RESET;
    m_request  = REQUEST_RESET;
    m_send_cnt = '0;
    m_send_sr  = '0;
    m_recv_cnt = '0;
    m_recv_sr  = '0;
    m_wr_ptr   = '0;
    m_rd_ptr   = '0;
    m_timer    = '0;
    m_timer_on = 1'b0;
    m_mode     = MODE_IDLE;
    m_data_bit = 1'b0;
  endfunction

  function automatic void timer_expire();
    m_timer_on = 1'b0;
    if (m_send_cnt == SEND_PENDING) begin
      m_timer    = m_timeout;
      m_timer_on = 1'b1;
      m_mode     = MODE_DRIVE;
      m_data_bit = 1'b0;
      m_send_cnt = SEND_FIRST;
    end
    m_recv_cnt = '0;
  endfunction

  function automatic void clock_edge(logic bit_in);
    m_timer    = m_timeout;
    m_timer_on = 1'b1;
    if (m_send_cnt == SEND_PENDING && m_recv_cnt == 0) begin
      m_timer = m_request;
    end else if (m_send_cnt != 0 && m_send_cnt != SEND_PENDING) begin
      if (m_send_cnt == SEND_RELEASE) begin
        m_mode = MODE_IDLE;
      end else if (m_send_cnt == SEND_ACK) begin
        m_timer_on = 1'b0;
      end else begin
        m_data_bit = m_send_sr[0];
        m_send_sr  = m_send_sr >> 1;
      end
      m_send_cnt = m_send_cnt - 1'b1;
    end else if (m_recv_cnt != 0) begin
      m_recv_sr  = {bit_in, m_recv_sr[9:1]};
      m_recv_cnt = m_recv_cnt - 1'b1;
      if (m_recv_cnt == 0) begin
        m_timer_on = 1'b0;
        if (m_wr_ptr + 2'd1 != m_rd_ptr) begin
          m_rx_mem[m_wr_ptr] = m_recv_sr[7:0];
          m_wr_ptr = m_wr_ptr + 2'd1;
        end
        if (m_send_cnt == SEND_PENDING) begin
          m_mode     = MODE_INHIBIT;
          m_timer    = m_request;
          m_timer_on = 1'b1;
        end
      end
    end else begin
      m_recv_cnt = RECV_BITS;
    end
  endfunction

  function automatic ps2hl_out_t apply_event(ps2hl_in_t it);
    ps2hl_out_t r;
    logic       empty;
    case (it.action)
      ACT_EDGE: clock_edge(it.data_in);
      ACT_TICK: begin
        if (m_timer_on) begin
          if (m_timer <= 1) begin
            m_timer = '0;
            timer_expire();
          end else begin
            m_timer = m_timer - 1'b1;
          end
        end
      end
      ACT_SEND: begin
        m_send_sr  = {~^it.command_byte, it.command_byte};
        m_send_cnt = SEND_PENDING;
        if (m_recv_cnt == 0) begin
          m_mode     = MODE_INHIBIT;
          m_timer    = m_request;
          m_timer_on = 1'b1;
        end
      end
      default: begin
        if (m_wr_ptr != m_rd_ptr) m_rd_ptr = m_rd_ptr + 2'd1;
      end
    endcase
    empty = (m_wr_ptr == m_rd_ptr);
    r.clock_drive_low   = (m_mode == MODE_INHIBIT);
    r.data_drive_enable = (m_mode == MODE_DRIVE);
    r.data_level        = (m_mode == MODE_DRIVE) ? m_data_bit : 1'b0;
    r.fifo_empty        = empty;
    r.fifo_head_byte    = empty ? '0 : m_rx_mem[m_rd_ptr];
    r.tx_idle           = (m_send_cnt == 0);
    return r;
  endfunction

  task automatic push_event(ps2hl_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        ev_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    ev_item  <= it;
    ev_valid <= 1'b1;
    @(posedge clk);
    while (!ev_ready) @(posedge clk);
    line_state_q.push_back(apply_event(it));
    sent_items++;
  endtask

  task automatic send_edge(logic bit_in);
    ps2hl_in_t it;
    it.action       = ACT_EDGE;
    it.data_in      = bit_in;
    it.command_byte = $urandom_range(0, 255);
    push_event(it);
  endtask

  task automatic send_tick();
    ps2hl_in_t it;
    it.action       = ACT_TICK;
    it.data_in      = $urandom_range(0, 1);
    it.command_byte = $urandom_range(0, 255);
    push_event(it);
  endtask

  task automatic send_command(logic [7:0] cmd);
    ps2hl_in_t it;
    it.action       = ACT_SEND;
    it.data_in      = $urandom_range(0, 1);
    it.command_byte = cmd;
    push_event(it);
  endtask

  task automatic send_pop();
    ps2hl_in_t it;
    it.action       = ACT_POP;
    it.data_in      = $urandom_range(0, 1);
    it.command_byte = $urandom_range(0, 255);
    push_event(it);
  endtask

  // hold off the sender until every result is back
  task automatic settle();
    ev_valid <= 1'b0;
    while (line_state_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [TIMER_W-1:0] timeout, logic [TIMER_W-1:0] request);
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= timeout;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_timeout = timeout;
    cfg_index <= CFG_REQUEST;
    cfg_data  <= request;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_request = request;
    cfg_valid <= 1'b0;
  endtask

  task automatic tick_while_running(int cap);
    int n;
    n = 0;
    while (m_timer_on && n < cap) begin
      send_tick();
      n++;
    end
  endtask

  task automatic test_idle_events();
    send_pop();
    send_tick();
  endtask

  task automatic test_receive_frame();
    send_edge(1'b1);
    repeat (8) send_edge(1'b1);
    send_edge(1'b1);
    send_edge(1'b1);
    send_pop();
  endtask

  task automatic test_send_command();
    send_command(8'hff);
    send_tick();
    repeat (11) send_edge(1'b0);
  endtask

  task automatic rx_frame();
    repeat (11) begin
      send_edge($urandom_range(0, 1));
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) send_tick();
      if ($urandom_range(0, 29) == 0) send_command($urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0) send_pop();
    end
  endtask

  task automatic tx_command(int cap);
    int n;
    case ($urandom_range(0, 9))
      0: send_command(8'h00);
      1: send_command(8'hff);
      default: send_command($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 7) == 0) send_edge($urandom_range(0, 1));
    n = 0;
    while (m_timer_on && m_send_cnt == SEND_PENDING && n < cap) begin
      send_tick();
      n++;
    end
    repeat (11) begin
      send_edge($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) send_tick();
      if ($urandom_range(0, 39) == 0) send_command($urandom_range(0, 255));
    end
  endtask

  task automatic abandon_frame(int cap);
    repeat ($urandom_range(1, 6)) send_edge($urandom_range(0, 1));
    tick_while_running(cap);
  endtask

  task automatic test_random_traffic(int target, int cap, int cmd_weight);
    int start;
    int pick;
    start = sent_items;
    while (sent_items - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        rx_frame();
      end else if (pick < 35 + cmd_weight) begin
        tx_command(cap);
      end else if (pick < 70) begin
        abandon_frame(cap);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3)) send_pop();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          ps2hl_in_t it;
          it = ps2hl_in_t'($urandom);
          push_event(it);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: res_ready <= 1'b1;
      1: res_ready <= $urandom_range(0, 1);
      2: res_ready <= ($urandom_range(0, 3) == 0);
      default: res_ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ps2hl_out_t want;
    if (!rst && res_valid && res_ready) begin
      if (line_state_q.size() == 0) begin
        $error("result with no item outstanding: %0h", res_item);
        errors++;
      end else begin
        want = line_state_q.pop_front();
        check_field("clock_drive_low", want.clock_drive_low, res_item.clock_drive_low);
        check_field("data_drive_enable", want.data_drive_enable, res_item.data_drive_enable);
        check_field("data_level", want.data_level, res_item.data_level);
        check_field("fifo_empty", want.fifo_empty, res_item.fifo_empty);
        check_field("fifo_head_byte", want.fifo_head_byte, res_item.fifo_head_byte);
        check_field("tx_idle", want.tx_idle, res_item.tx_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    reset_link_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_events();
    settle();
    write_regs(16'd2, 16'd1);
    test_receive_frame();
    test_send_command();

    settle();
    write_regs(16'd12, 16'd3);
    test_random_traffic(400, 100, 25);
    settle();
    write_regs(16'd1, 16'd65535);
    test_random_traffic(150, 40, 3);
    settle();
    write_regs(16'd65535, 16'd1);
    test_random_traffic(400, 40, 20);
    settle();
    write_regs(16'd40, 16'd8);
    test_random_traffic(450, 100, 25);
    settle();
    write_regs(16'd5, 16'd2);
    test_random_traffic(450, 100, 25);

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0 && line_state_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
